// ===== design/binomial_coefficient_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the binomial coefficient unit
// Concurrent checks sampled on the rising edge of clock.
// ---------------------------------------------------------------------------
`ifndef BINOMIAL_COEFFICIENT_UNIT_ASSERT_SVH
`define BINOMIAL_COEFFICIENT_UNIT_ASSERT_SVH

// Implication checked only outside of reset.
`define BCU_ASSERT_IMPLY(label, cond, expect_expr) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (cond) |-> (expect_expr)) else $error("bcu assertion failed");

// Implication checked also across reset.
`define BCU_ASSERT_ALWAYS(label, cond, expect_expr) \
   label: assert property (@(posedge clock) \
      (cond) |-> (expect_expr)) else $error("bcu assertion failed");

`endif

// ===== design/bcu_pkg.sv =====
// ---------------------------------------------------------------------------
// bcu_pkg
// Shared types and constants of the binomial coefficient unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcu_pkg;

   // Width of the result word and of one half of it.
   localparam int COEF_WIDTH = 64;
   localparam int HALF_WIDTH = 32;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_WIDTH = 1;

   // Class of one word, decided by the front.
   typedef enum logic [1:0] {
      KIND_INVALID = 2'd0,   // r above n
      KIND_UNIT    = 2'd1,   // min(r, n-r) is zero
      KIND_TOTAL   = 2'd2,   // min(r, n-r) is one
      KIND_ITERATE = 2'd3    // needs the multiply-divide loop
   } kind_type;

endpackage

// ===== design/bcu_front.sv =====
// ---------------------------------------------------------------------------
// bcu_front
// Accepts request words, classifies them and pushes them into the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcu_front #(
   parameter int COUNT_WIDTH = 10,
   parameter int WORD_WIDTH  = 22
) (
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [COUNT_WIDTH-1:0] req_total_count,
   input  logic [COUNT_WIDTH-1:0] req_choose_count,
   input  logic                   queue_ready,
   output logic                   queue_push,
   output logic [WORD_WIDTH-1:0]  queue_word
);

   logic [COUNT_WIDTH-1:0] rest_count;
   logic [COUNT_WIDTH-1:0] small_count;
   bcu_pkg::kind_type      kind;

   always_comb begin
      rest_count  = req_total_count - req_choose_count;
      small_count = (rest_count < req_choose_count) ? rest_count : req_choose_count;
      if (req_choose_count > req_total_count) begin
         kind = bcu_pkg::KIND_INVALID;
      end else if (small_count == '0) begin
         kind = bcu_pkg::KIND_UNIT;
      end else if (small_count == COUNT_WIDTH'(1)) begin
         kind = bcu_pkg::KIND_TOTAL;
      end else begin
         kind = bcu_pkg::KIND_ITERATE;
      end
   end

   assign req_ready  = queue_ready;
   assign queue_push = req_valid & queue_ready;
   assign queue_word = {kind, req_total_count, small_count};

endmodule

// ===== design/bcu_queue.sv =====
// ---------------------------------------------------------------------------
// bcu_queue
// Short first-in first-out queue between front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcu_queue #(
   parameter int WORD_WIDTH = 22
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [WORD_WIDTH-1:0] push_word,
   output logic                  push_ready,
   output logic                  pop_valid,
   input  logic                  pop,
   output logic [WORD_WIDTH-1:0] pop_word
);

   localparam int CNT_WIDTH = $clog2(bcu_pkg::QUEUE_DEPTH + 1);

   logic [WORD_WIDTH-1:0]                mem_ff [bcu_pkg::QUEUE_DEPTH];
   logic [bcu_pkg::QUEUE_PTR_WIDTH-1:0]  wr_ptr_ff;
   logic [bcu_pkg::QUEUE_PTR_WIDTH-1:0]  rd_ptr_ff;
   logic [CNT_WIDTH-1:0]                 count_ff;
   logic                                 do_push;
   logic                                 do_pop;

   assign push_ready = (count_ff != CNT_WIDTH'(bcu_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push & push_ready;
   assign do_pop     = pop & pop_valid;
   assign pop_word   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== design/bcu_back.sv =====
// ---------------------------------------------------------------------------
// bcu_back
// Runs the multiply and exact divide steps and holds the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcu_back #(
   parameter int COUNT_WIDTH = 10,
   parameter int WORD_WIDTH  = 22
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          queue_valid,
   output logic                          queue_pop,
   input  logic [WORD_WIDTH-1:0]         queue_word,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bcu_pkg::COEF_WIDTH-1:0] rsp_coefficient,
   output logic                          rsp_overflow,
   output logic                          rsp_invalid
);

   localparam int CW         = COUNT_WIDTH;
   localparam int HW         = bcu_pkg::HALF_WIDTH;
   localparam int RW         = bcu_pkg::COEF_WIDTH;
   localparam int PART_WIDTH = HW + CW;
   localparam int PROD_WIDTH = RW + CW;
   localparam int BIT_WIDTH  = $clog2(PROD_WIDTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_SUM,
      ST_DIV,
      ST_CHECK,
      ST_FINISH
   } state_type;

   state_type               state_ff,     state_in;
   logic [RW-1:0]           acc_ff,       acc_in;
   logic                    ovf_ff,       ovf_in;
   logic                    inv_ff,       inv_in;
   logic [CW-1:0]           term_ff,      term_in;
   logic [CW-1:0]           step_ff,      step_in;
   logic [CW-1:0]           limit_ff,     limit_in;
   logic [PART_WIDTH-1:0]   part_lo_ff,   part_lo_in;
   logic [PART_WIDTH-1:0]   part_hi_ff,   part_hi_in;
   logic [PROD_WIDTH-1:0]   quot_ff,      quot_in;
   logic [CW-1:0]           rem_ff,       rem_in;
   logic [BIT_WIDTH-1:0]    bit_ff,       bit_in;
   logic                    out_valid_ff, out_valid_in;
   logic [RW-1:0]           out_coef_ff,  out_coef_in;
   logic                    out_ovf_ff,   out_ovf_in;
   logic                    out_inv_ff,   out_inv_in;

   bcu_pkg::kind_type       word_kind;
   logic [CW-1:0]           word_total;
   logic [CW-1:0]           word_small;
   logic [CW:0]             rem_shift;
   logic [CW:0]             rem_diff;
   logic                    quot_bit;

   assign word_kind  = bcu_pkg::kind_type'(queue_word[WORD_WIDTH-1 -: 2]);
   assign word_total = queue_word[2*CW-1 -: CW];
   assign word_small = queue_word[CW-1:0];

   // One restoring division bit per cycle.
   assign rem_shift = {rem_ff, quot_ff[PROD_WIDTH-1]};
   assign rem_diff  = rem_shift - {1'b0, step_ff};
   assign quot_bit  = (rem_shift >= {1'b0, step_ff});

   assign queue_pop       = (state_ff == ST_IDLE);
   assign rsp_valid       = out_valid_ff;
   assign rsp_coefficient = out_coef_ff;
   assign rsp_overflow    = out_ovf_ff;
   assign rsp_invalid     = out_inv_ff;

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      ovf_in       = ovf_ff;
      inv_in       = inv_ff;
      term_in      = term_ff;
      step_in      = step_ff;
      limit_in     = limit_ff;
      part_lo_in   = part_lo_ff;
      part_hi_in   = part_hi_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      out_valid_in = out_valid_ff & ~rsp_ready;
      out_coef_in  = out_coef_ff;
      out_ovf_in   = out_ovf_ff;
      out_inv_in   = out_inv_ff;

      case (state_ff)
         ST_IDLE: begin
            if (queue_valid) begin
               ovf_in = 1'b0;
               inv_in = 1'b0;
               case (word_kind)
                  bcu_pkg::KIND_INVALID: begin
                     acc_in   = '0;
                     inv_in   = 1'b1;
                     state_in = ST_FINISH;
                  end
                  bcu_pkg::KIND_UNIT: begin
                     acc_in   = RW'(1);
                     state_in = ST_FINISH;
                  end
                  bcu_pkg::KIND_TOTAL: begin
                     acc_in   = RW'(word_total);
                     state_in = ST_FINISH;
                  end
                  default: begin
                     acc_in   = RW'(1);
                     term_in  = word_total - word_small + CW'(1);
                     step_in  = CW'(1);
                     limit_in = word_small;
                     state_in = ST_MUL_LO;
                  end
               endcase
            end
         end
         ST_MUL_LO: begin
            part_lo_in = PART_WIDTH'(acc_ff[HW-1:0]) * PART_WIDTH'(term_ff);
            state_in   = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            part_hi_in = PART_WIDTH'(acc_ff[RW-1:HW]) * PART_WIDTH'(term_ff);
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            quot_in  = {part_hi_ff, {HW{1'b0}}} + PROD_WIDTH'(part_lo_ff);
            rem_in   = '0;
            bit_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            quot_in = {quot_ff[PROD_WIDTH-2:0], quot_bit};
            rem_in  = quot_bit ? rem_diff[CW-1:0] : rem_shift[CW-1:0];
            bit_in  = bit_ff + 1'b1;
            if (bit_ff == BIT_WIDTH'(PROD_WIDTH - 1)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (quot_ff[PROD_WIDTH-1:RW] != '0) begin
               acc_in   = '1;
               ovf_in   = 1'b1;
               state_in = ST_FINISH;
            end else begin
               acc_in = quot_ff[RW-1:0];
               if (step_ff == limit_ff) begin
                  state_in = ST_FINISH;
               end else begin
                  step_in  = step_ff + CW'(1);
                  term_in  = term_ff + CW'(1);
                  state_in = ST_MUL_LO;
               end
            end
         end
         ST_FINISH: begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in = 1'b1;
               out_coef_in  = acc_ff;
               out_ovf_in   = ovf_ff;
               out_inv_in   = inv_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      acc_ff      <= acc_in;
      ovf_ff      <= ovf_in;
      inv_ff      <= inv_in;
      term_ff     <= term_in;
      step_ff     <= step_in;
      limit_ff    <= limit_in;
      part_lo_ff  <= part_lo_in;
      part_hi_ff  <= part_hi_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      bit_ff      <= bit_in;
      out_coef_ff <= out_coef_in;
      out_ovf_ff  <= out_ovf_in;
      out_inv_ff  <= out_inv_in;
   end

endmodule

// ===== design/binomial_coefficient_unit.sv =====
// Binomial coefficient unit: each request word carries n and r and yields one
// response word with the exact C(n,r), all ones plus overflow when the value
// needs more than 64 bits, or zero plus invalid when r is above n. With the
// back end idle, words with min(r, n-r) of 0 or 1, and invalid words, pass
// through the queue, the idle state and the finish state into the response
// register. Other words add k = min(r, n-r) steps of two multiply states, a
// sum state, the bit-serial exact divider that produces one quotient bit per
// cycle over the 64+COUNT_WIDTH bit product, and a check state; the loop
// stops at the first step that overflows. Requests are taken into a
// two-word queue while the back end works, and a finished response waits in
// its own register.
// ---------------------------------------------------------------------------
// binomial_coefficient_unit
// Top level: classifying front end, word queue and iterative back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module binomial_coefficient_unit #(
   parameter int COUNT_WIDTH = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [COUNT_WIDTH-1:0]         req_total_count,
   input  logic [COUNT_WIDTH-1:0]         req_choose_count,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [bcu_pkg::COEF_WIDTH-1:0] rsp_coefficient,
   output logic                           rsp_overflow,
   output logic                           rsp_invalid
);

   // Queue word: class, n and min(r, n-r).
   localparam int WORD_WIDTH = $bits(bcu_pkg::kind_type) + 2 * COUNT_WIDTH;

   logic                  queue_ready;
   logic                  queue_push;
   logic [WORD_WIDTH-1:0] push_word;
   logic                  queue_valid;
   logic                  queue_pop;
   logic [WORD_WIDTH-1:0] pop_word;

   // Classify the request and push it when the queue has room.
   bcu_front #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .WORD_WIDTH  (WORD_WIDTH)
   ) u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_total_count  (req_total_count),
      .req_choose_count (req_choose_count),
      .queue_ready      (queue_ready),
      .queue_push       (queue_push),
      .queue_word       (push_word)
   );

   // Hold classified words until the back end is free.
   bcu_queue #(
      .WORD_WIDTH (WORD_WIDTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_word  (push_word),
      .push_ready (queue_ready),
      .pop_valid  (queue_valid),
      .pop        (queue_pop),
      .pop_word   (pop_word)
   );

   // Multiply, divide exactly, and drive the response register.
   bcu_back #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .WORD_WIDTH  (WORD_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_valid     (queue_valid),
      .queue_pop       (queue_pop),
      .queue_word      (pop_word),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_coefficient (rsp_coefficient),
      .rsp_overflow    (rsp_overflow),
      .rsp_invalid     (rsp_invalid)
   );

`include "binomial_coefficient_unit_assert.svh"

   // An invalid word carries a zero coefficient and no overflow.
   `BCU_ASSERT_IMPLY(a_invalid_zero, rsp_valid && rsp_invalid,
                     rsp_coefficient == '0 && !rsp_overflow)
   // A saturated word carries all ones.
   `BCU_ASSERT_IMPLY(a_overflow_ones, rsp_valid && rsp_overflow, rsp_coefficient == '1)
   // No response word right after reset.
   `BCU_ASSERT_ALWAYS(a_reset_empty, $past(reset), !rsp_valid)

endmodule
